>>> rtl/core/pcx_pkg.sv
package pcx_pkg;

	// Line store geometry and register widths
	localparam int MAX_LINE_BYTES = 2048;
	localparam int COL_W          = 11;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int RUN_W          = 6;

	// Stream byte codes
	localparam logic [7:0]       RUN_MARK       = 8'hC0;
	localparam logic [RUN_W-1:0] RUN_COUNT_MASK = 6'h3F;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 1'b1;

	// Register reset values and clamp limit
	localparam logic [CFG_W-1:0] BPL_RESET   = 12'd320;
	localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd320;
	localparam logic [CFG_W-1:0] BPL_MAX     = 12'd2048;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_PLACE,
		ST_LOAD
	} state_t;

	typedef enum logic [1:0] {
		PLANE_RED,
		PLANE_GREEN,
		PLANE_BLUE
	} plane_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic place;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic start_run;
		logic emit;
		logic finish;
		logic finish_s1;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/pcx_dp.sv
module pcx_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pcx_pkg::cmd_t      cmd,
	output pcx_pkg::sts_t      sts,
	input  logic [7:0]         s_tdata,
	input  logic               cfg_valid,
	input  logic [pcx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcx_pkg::CFG_W-1:0]     cfg_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	logic [pcx_pkg::CFG_W-1:0] bpl_q;
	logic [pcx_pkg::CFG_W-1:0] width_q;
	logic                      awaiting_q;
	logic [pcx_pkg::RUN_W-1:0] run_len_q;
	logic [pcx_pkg::RUN_W-1:0] rem_q;
	logic [7:0]                byte_q;
	pcx_pkg::plane_t           plane_q;
	logic [pcx_pkg::COL_W-1:0] col_q;

	logic [pcx_pkg::COL_W-1:0] pix_col_s1;
	logic                      line_end_s1;
	logic                      last_s1;
	logic                      finish_s1;
	logic [7:0]                rd_red_s1;
	logic [7:0]                rd_green_s1;

	logic                      m_tvalid_q;
	logic [39:0]               m_tdata_q;
	logic                      m_tuser_q;
	logic                      m_tlast_q;

	logic [7:0] red_mem   [pcx_pkg::MAX_LINE_BYTES];
	logic [7:0] green_mem [pcx_pkg::MAX_LINE_BYTES];

	logic                      is_header;
	logic [pcx_pkg::CFG_W-1:0] bpl_eff;
	logic [pcx_pkg::CFG_W-1:0] width_eff;
	logic [pcx_pkg::CFG_W-1:0] col_ext;
	logic [pcx_pkg::CFG_W-1:0] col_nxt;
	logic                      line_done;
	logic                      rem_last;
	logic                      line_end_c;
	logic                      emit_c;
	pcx_pkg::plane_t           plane_nxt;

	// Decode and clamp the line geometry
	always_comb begin
		is_header = (s_tdata & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK;
		if (bpl_q == '0) begin
			bpl_eff = 12'd1;
		end else if (bpl_q > pcx_pkg::BPL_MAX) begin
			bpl_eff = pcx_pkg::BPL_MAX;
		end else begin
			bpl_eff = bpl_q;
		end
		width_eff  = (width_q < bpl_eff) ? width_q : bpl_eff;
		col_ext    = {1'b0, col_q};
		col_nxt    = col_ext + 12'd1;
		line_done  = col_nxt >= bpl_eff;
		rem_last   = rem_q == 6'd1;
		line_end_c = col_nxt == width_eff;
		emit_c     = (plane_q == pcx_pkg::PLANE_BLUE) && (col_ext < width_eff);
	end

	// Plane sequence, blue wraps to the next line's red
	always_comb begin
		unique case (plane_q)
			pcx_pkg::PLANE_RED:   plane_nxt = pcx_pkg::PLANE_GREEN;
			pcx_pkg::PLANE_GREEN: plane_nxt = pcx_pkg::PLANE_BLUE;
			default:              plane_nxt = pcx_pkg::PLANE_RED;
		endcase
	end

	// Status to the controller
	always_comb begin
		sts.start_run = awaiting_q ? (run_len_q != '0) : !is_header;
		sts.emit      = emit_c;
		sts.finish    = rem_last || (line_done && (plane_q == pcx_pkg::PLANE_BLUE));
		sts.finish_s1 = finish_s1;
		sts.out_free  = !m_tvalid_q || m_tready;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpl_q   <= pcx_pkg::BPL_RESET;
			width_q <= pcx_pkg::WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcx_pkg::CFG_BYTES_PER_LINE: bpl_q   <= cfg_data;
				default:                     width_q <= cfg_data;
			endcase
		end
	end

	// Run decode and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			run_len_q  <= '0;
			rem_q      <= '0;
			byte_q     <= '0;
			plane_q    <= pcx_pkg::PLANE_RED;
			col_q      <= '0;
		end else if (cmd.take) begin
			byte_q <= s_tdata;
			if (awaiting_q) begin
				awaiting_q <= 1'b0;
				rem_q      <= run_len_q;
			end else if (is_header) begin
				awaiting_q <= 1'b1;
				run_len_q  <= s_tdata[pcx_pkg::RUN_W-1:0] & pcx_pkg::RUN_COUNT_MASK;
			end else begin
				rem_q <= 6'd1;
			end
		end else if (cmd.place) begin
			rem_q <= rem_q - 6'd1;
			if (line_done) begin
				col_q   <= '0;
				plane_q <= plane_nxt;
			end else begin
				col_q <= col_nxt[pcx_pkg::COL_W-1:0];
			end
		end
	end

	// Pixel held between placement and output load
	always_ff @(posedge clk) begin
		if (cmd.place && emit_c) begin
			pix_col_s1  <= col_q;
			line_end_s1 <= line_end_c;
			last_s1     <= rem_last || line_end_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_s1 <= 1'b0;
		end else if (cmd.place && emit_c) begin
			finish_s1 <= sts.finish;
		end
	end

	// Red and green line stores, registered read
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			if (plane_q == pcx_pkg::PLANE_RED) begin
				red_mem[col_q] <= byte_q;
			end
			if (plane_q == pcx_pkg::PLANE_GREEN) begin
				green_mem[col_q] <= byte_q;
			end
			rd_red_s1   <= red_mem[col_q];
			rd_green_s1 <= green_mem[col_q];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= {5'b0, pix_col_s1, byte_q, rd_green_s1, rd_red_s1};
			m_tuser_q <= line_end_s1;
			m_tlast_q <= last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> rtl/core/pcx_ctrl.sv
module pcx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  pcx_pkg::sts_t sts,
	output pcx_pkg::cmd_t cmd
);

	pcx_pkg::state_t state_q;
	pcx_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcx_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pcx_pkg::ST_ACCEPT: begin
				if (s_tvalid && sts.start_run) begin
					state_nxt = pcx_pkg::ST_PLACE;
				end
			end
			pcx_pkg::ST_PLACE: begin
				priority if (sts.emit) begin
					state_nxt = pcx_pkg::ST_LOAD;
				end else if (sts.finish) begin
					state_nxt = pcx_pkg::ST_ACCEPT;
				end
			end
			pcx_pkg::ST_LOAD: begin
				if (sts.out_free) begin
					state_nxt = sts.finish_s1 ? pcx_pkg::ST_ACCEPT : pcx_pkg::ST_PLACE;
				end
			end
			default: state_nxt = pcx_pkg::ST_ACCEPT;
		endcase
	end

	// Commands
	always_comb begin
		s_tready  = state_q == pcx_pkg::ST_ACCEPT;
		cmd.take  = (state_q == pcx_pkg::ST_ACCEPT) && s_tvalid;
		cmd.place = state_q == pcx_pkg::ST_PLACE;
		cmd.load  = (state_q == pcx_pkg::ST_LOAD) && sts.out_free;
	end

endmodule

>>> rtl/core/pcx_rle_planar_rgb_decoder.sv
// PCX 24-bit RLE decoder: one compressed byte per request in, one RGB pixel per output beat out.
// A header byte is only taken; any other byte is taken and then placed once per repeat of its
// run, and each placement of a blue byte within the image width also loads a pixel, waiting
// while the output is stalled. No new byte is taken while a run is still being placed.
// A pixel goes from its accepted byte through the place and load states to the output register.
// Reset (arst_n low, asynchronous) clears control state; the line store is not cleared.
module pcx_rle_planar_rgb_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: in_byte[7:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// tdata: red[7:0], green[15:8], blue[23:16], pixel_column[34:24], zero[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// tuser: line_end[0]
	output logic        m_tuser,
	// tlast: last
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	pcx_pkg::cmd_t cmd;
	pcx_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> rtl/core/pcx_chk.sv
module pcx_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// A stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output changed");

	// The end-of-line pixel always closes the request's results
	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("line_end without last");

	// More pixels of the same request pending: no new input taken
	a_no_input_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while request still emitting");

	// A pixel is loaded only from the load step, never while accepting
	a_load_not_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("pixel loaded while accepting input");

endmodule

bind pcx_rle_planar_rgb_decoder pcx_chk u_pcx_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
